// ===== rtl/core/shabs_pkg.sv =====
// ----------------------------------------------------------------------------
// shabs_pkg
// Types, round constants and helpers shared by the SHA-256 byte stream hasher
// ----------------------------------------------------------------------------
package shabs_pkg;

    // eight 32-bit hash words, index 0 is word a / digest word 0
    typedef logic [31:0] hash_words_t [8];

    // sixteen schedule words; index 15 holds the oldest word W[t]
    typedef logic [15:0][31:0] window_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    localparam hash_words_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/shabs_round.sv =====
// ----------------------------------------------------------------------------
// shabs_round
// One SHA-256 round and one message schedule step, shared by all 64 rounds
// ----------------------------------------------------------------------------
module shabs_round import shabs_pkg::*; (
    input  hash_words_t vars_i,
    input  logic [31:0] k_i,
    input  window_t     win_i,
    output hash_words_t vars_o,
    output logic [31:0] sched_o
);

    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] sum1;
    logic [31:0] sum2;
    logic [31:0] sig0;
    logic [31:0] sig1;

    always_comb begin
        big1   = rotr(vars_i[4], 6) ^ rotr(vars_i[4], 11) ^ rotr(vars_i[4], 25);
        choose = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
        sum1   = vars_i[7] + big1 + choose + k_i + win_i[15];
        big0   = rotr(vars_i[0], 2) ^ rotr(vars_i[0], 13) ^ rotr(vars_i[0], 22);
        major  = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
        sum2   = big0 + major;

        vars_o[7] = vars_i[6];
        vars_o[6] = vars_i[5];
        vars_o[5] = vars_i[4];
        vars_o[4] = vars_i[3] + sum1;
        vars_o[3] = vars_i[2];
        vars_o[2] = vars_i[1];
        vars_o[1] = vars_i[0];
        vars_o[0] = sum1 + sum2;

        // W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
        sig0    = rotr(win_i[14], 7) ^ rotr(win_i[14], 18) ^ (win_i[14] >> 3);
        sig1    = rotr(win_i[1], 17) ^ rotr(win_i[1], 19) ^ (win_i[1] >> 10);
        sched_o = win_i[15] + sig0 + win_i[6] + sig1;
    end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, digest returned as eight 32-bit words
// ----------------------------------------------------------------------------
//  channel  ports                                          role
//  s_       s_valid s_ready s_data_byte s_has_byte         message bytes in
//           s_end_of_message
//  m_       m_valid m_ready m_digest_word m_word_number    digest words out
//           m_last_word
//
//  a byte is taken while idle; the byte that fills a block holds s_ready low
//  through the 64 rounds in the shared round unit and the add
//  an end item feeds in one padding byte at a time (up to 72), runs the rounds
//  and the add per padded block, then offers the eight words; m_ready stalls only the output
//  reset (aresetn low, synchronous) loads the initial hash and clears counts
//  s_ready is high only while idle
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher import shabs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_number,
    output logic        m_last_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    window_t     win_reg, win_next;
    hash_words_t chain_reg, chain_next;
    hash_words_t vars_reg, vars_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  word_reg, word_next;
    logic        pad_mark_reg, pad_mark_next;
    logic        final_reg, final_next;
    logic        end_pend_reg, end_pend_next;

    hash_words_t round_vars;
    logic [31:0] round_sched;
    logic [7:0]  pad_byte;
    logic [5:0]  len_idx;
    logic [$bits(window_t)-1:0] win_flat;

    shabs_round u_round (
        .vars_i  (vars_reg),
        .k_i     (ROUND_K[round_reg]),
        .win_i   (win_reg),
        .vars_o  (round_vars),
        .sched_o (round_sched)
    );

    assign win_flat = win_reg;

    // length bytes go out most significant first
    assign len_idx = {~fill_reg[2:0], 3'b000};

    always_comb begin
        if (!pad_mark_reg) begin
            pad_byte = PAD_BYTE;
        end else if (final_reg && fill_reg >= LENGTH_POS) begin
            pad_byte = bits_reg[len_idx +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        state_next    = state_reg;
        win_next      = win_reg;
        chain_next    = chain_reg;
        vars_next     = vars_reg;
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        round_next    = round_reg;
        word_next     = word_reg;
        pad_mark_next = pad_mark_reg;
        final_next    = final_reg;
        end_pend_next = end_pend_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_has_byte) begin
                        win_next  = window_t'({win_flat[$bits(window_t)-9:0], s_data_byte});
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + BYTE_BITS;
                    end
                    if (s_has_byte && fill_reg == LAST_FILL) begin
                        vars_next     = chain_reg;
                        round_next    = '0;
                        end_pend_next = s_end_of_message;
                        state_next    = ST_ROUND;
                    end else if (s_end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                win_next  = window_t'({win_flat[$bits(window_t)-9:0], pad_byte});
                fill_next = fill_reg + 6'd1;
                if (!pad_mark_reg) begin
                    pad_mark_next = 1'b1;
                    // length fits behind the marker only below the length field
                    final_next    = (fill_reg < LENGTH_POS);
                end
                if (fill_reg == LAST_FILL) begin
                    vars_next  = chain_reg;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                vars_next  = round_vars;
                win_next   = {win_reg[14:0], round_sched};
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                if (pad_mark_reg) begin
                    if (final_reg) begin
                        word_next  = '0;
                        state_next = ST_OUT;
                    end else begin
                        final_next = 1'b1;
                        state_next = ST_PAD;
                    end
                end else if (end_pend_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == LAST_WORD) begin
                        chain_next    = INIT_HASH;
                        bits_next     = '0;
                        fill_next     = '0;
                        pad_mark_next = 1'b0;
                        final_next    = 1'b0;
                        end_pend_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chain_reg    <= INIT_HASH;
            fill_reg     <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            word_reg     <= '0;
            pad_mark_reg <= 1'b0;
            final_reg    <= 1'b0;
            end_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            round_reg    <= round_next;
            word_reg     <= word_next;
            pad_mark_reg <= pad_mark_next;
            final_reg    <= final_next;
            end_pend_reg <= end_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[word_reg];
    assign m_word_number = word_reg;
    assign m_last_word   = (word_reg == LAST_WORD);

endmodule

// ===== bench/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 byte stream hasher, predicts each
// digest from the accepted input words and compares the digest words out
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_digest_word,
    input  logic [2:0]  m_word_number,
    input  logic        m_last_word,
    output int          mismatches,
    output int          words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int         BLOCK_BYTES = 64;
    localparam int         LEN_OFFSET  = 56;

    logic [31:0]  chain [8];
    logic [7:0]   blk [BLOCK_BYTES];
    int unsigned  fill;
    logic [63:0]  msg_bits;
    digest_word_t digest_queue [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] xx;
        xx = {x, x} >> n;
        return xx[31:0];
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, ch, maj, t1, t2;
        for (int t = 0; t < 16; t++) begin
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int t = 0; t < 8; t++) begin
            v[t] = chain[t];
        end
        for (int t = 0; t < 64; t++) begin
            s1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + SHA_K[t] + w[t];
            s0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) begin
            chain[t] = chain[t] + v[t];
        end
    endfunction

    function automatic void restart_message();
        for (int k = 0; k < 8; k++) begin
            chain[k] = SHA_IV[k];
        end
        fill = 0;
        msg_bits = '0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic absorb_word(input logic [7:0] data, input logic has, input logic last);
        digest_word_t dw;
        if (has) begin
            blk[fill] = data;
            fill++;
            msg_bits += 64'd8;
            if (fill == BLOCK_BYTES) begin
                compress_block();
                fill = 0;
            end
        end
        if (!last) begin
            return;
        end
        blk[fill] = PAD_MARK;
        fill++;
        // no room left for the length: close this block and open another
        if (fill > LEN_OFFSET) begin
            while (fill < BLOCK_BYTES) begin
                blk[fill] = 8'h00;
                fill++;
            end
            compress_block();
            fill = 0;
        end
        while (fill < LEN_OFFSET) begin
            blk[fill] = 8'h00;
            fill++;
        end
        for (int k = 0; k < 8; k++) begin
            blk[LEN_OFFSET + k] = msg_bits[63 - 8*k -: 8];
        end
        compress_block();
        for (int k = 0; k < 8; k++) begin
            dw.digest = chain[k];
            dw.index  = 3'(k);
            dw.last   = (k == 7);
            digest_queue.push_back(dw);
        end
        restart_message();
    endtask

    task automatic check_word();
        digest_word_t want;
        if (digest_queue.size() == 0) begin
            report_mismatch($sformatf("digest word %h with nothing owed", m_digest_word));
            return;
        end
        want = digest_queue.pop_front();
        if (m_digest_word !== want.digest) begin
            report_mismatch($sformatf("word %0d digest_word %h, want %h",
                                      want.index, m_digest_word, want.digest));
        end
        if (m_word_number !== want.index) begin
            report_mismatch($sformatf("word_number %0d, want %0d", m_word_number, want.index));
        end
        if (m_last_word !== want.last) begin
            report_mismatch($sformatf("word %0d last_word %b, want %b",
                                      want.index, m_last_word, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                blk[k] = 8'h00;
            end
            restart_message();
            digest_queue.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_word();
            end
            if (s_valid && s_ready) begin
                absorb_word(s_data_byte, s_has_byte, s_end_of_message);
            end
        end
        words_owed = digest_queue.size();
    end

endmodule

// ===== bench/tb_sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// Feeds short directed messages and then random byte streams into the hasher
// in bursts, stalls the digest output on a pattern of its own with one long
// hold-off, and lets the checker compare every digest word
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STREAM_BYTES = 500;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_has_byte;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_number;
    logic        m_last_word;

    int   mismatches;
    int   words_owed;
    int   burst_left = 0;
    logic random_phase = 1'b0;

    sha256_byte_stream_hasher u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_has_byte       (s_has_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digest_word    (m_digest_word),
        .m_word_number    (m_word_number),
        .m_last_word      (m_last_word)
    );

    sha256_digest_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_has_byte       (s_has_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digest_word    (m_digest_word),
        .m_word_number    (m_word_number),
        .m_last_word      (m_last_word),
        .mismatches       (mismatches),
        .words_owed       (words_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // offers one word, opening a new burst after a random gap when the last one ran out
    task automatic offer_word(input logic [7:0] data, input logic has, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_data_byte      <= data;
        s_has_byte       <= has;
        s_end_of_message <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // receiver: stall segments of random density, plus one long hold-off
    initial begin
        int seg_left;
        int stall_pct;
        int hold_delay;
        int hold_left;
        logic hold_done;
        seg_left   = 0;
        stall_pct  = 0;
        hold_delay = $urandom_range(200, 1200);
        hold_left  = 0;
        hold_done  = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (random_phase && !hold_done) begin
                if (hold_delay > 0) begin
                    hold_delay--;
                end else begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 300);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
            @(posedge aclk);
        end
    end

    initial begin
        int   stream_count;
        int   msg_len;
        logic close_on_byte;
        int   boundary_lengths [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        s_valid          <= 1'b0;
        s_data_byte      <= 8'h00;
        s_has_byte       <= 1'b0;
        s_end_of_message <= 1'b0;
        aresetn          <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message straight after reset
        offer_word(8'h00, 1'b0, 1'b1);
        // "abc", end flag on the final byte
        offer_word(8'h61, 1'b1, 1'b0);
        offer_word(8'h62, 1'b1, 1'b0);
        offer_word(8'h63, 1'b1, 1'b1);
        // idle words change nothing, whatever the data, then two one-byte messages
        offer_word(8'hff, 1'b0, 1'b0);
        offer_word(8'h00, 1'b0, 1'b0);
        offer_word(8'hff, 1'b1, 1'b1);
        offer_word(8'h00, 1'b1, 1'b1);
        // bytes, an idle word, then an empty end word whose data is ignored
        offer_word(8'h5a, 1'b1, 1'b0);
        offer_word(8'hc3, 1'b0, 1'b0);
        offer_word(8'ha5, 1'b1, 1'b0);
        offer_word(8'hff, 1'b0, 1'b1);
        // back-to-back empty messages
        offer_word(8'h3c, 1'b0, 1'b1);
        offer_word(8'h00, 1'b0, 1'b1);

        random_phase = 1'b1;
        stream_count = 0;
        while (stream_count < STREAM_BYTES) begin
            case ($urandom_range(0, 9))
                7, 8:    msg_len = boundary_lengths[$urandom_range(0, 7)];
                9:       msg_len = $urandom_range(0, 140);
                default: msg_len = $urandom_range(0, 16);
            endcase
            close_on_byte = $urandom_range(0, 1);
            for (int i = 0; i < msg_len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    offer_word(8'($urandom), 1'b0, 1'b0);
                end
                offer_word(8'($urandom), 1'b1, close_on_byte && (i == msg_len - 1));
                stream_count++;
            end
            if (msg_len == 0 || !close_on_byte) begin
                offer_word(8'($urandom), 1'b0, 1'b1);
                stream_count++;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (words_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && words_owed == 0) begin
            $display("tb_sha256_byte_stream_hasher OK");
        end else begin
            $display("tb_sha256_byte_stream_hasher NOT OK");
        end
        $finish;
    end

    initial begin
        #(64'd20_000_000);
        $display("tb_sha256_byte_stream_hasher NOT OK");
        $finish;
    end

endmodule

// ===== sha256_byte_stream_hasher.f =====
rtl/core/shabs_pkg.sv
rtl/core/shabs_round.sv
rtl/core/sha256_byte_stream_hasher.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_byte_stream_hasher.sv
